// ===== hw/rtl/pca_pkg.sv =====
// ---------------------------------------------------------------------------
// pca_pkg
// Shared constants, codes and types of the priority capacity admission block.
// ---------------------------------------------------------------------------
package pca_pkg;

   localparam int RESV_DEPTH = 32;
   localparam int WAIT_DEPTH = 8;
   localparam int ID_BITS    = 8;

   localparam int RIDX_W = $clog2(RESV_DEPTH);
   localparam int RCNT_W = $clog2(RESV_DEPTH + 1);
   localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

   localparam int MODE_W   = 3;
   localparam int CLIENT_W = 8;
   localparam int BYTES_W  = 48;
   localparam int PRIO_W   = 8;
   localparam int TICK_W   = 16;
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_W = CLIENT_W + BYTES_W + PRIO_W + TICK_W;
   localparam int RSP_DATA_W = CLIENT_W + 2 * BYTES_W;
   localparam int RSP_USER_W = 1 + STATUS_W;

   localparam logic [BYTES_W-1:0] CAP_RESET   = 48'h0004_0000_0000;
   localparam logic [TICK_W-1:0]  TMO_FOREVER = 16'hFFFF;

   localparam logic [MODE_W-1:0] OP_TRY    = 3'd0;
   localparam logic [MODE_W-1:0] OP_WAIT   = 3'd1;
   localparam logic [MODE_W-1:0] OP_REL    = 3'd2;
   localparam logic [MODE_W-1:0] OP_MACQ   = 3'd3;
   localparam logic [MODE_W-1:0] OP_MREL   = 3'd4;
   localparam logic [MODE_W-1:0] OP_TICK   = 3'd5;
   localparam logic [MODE_W-1:0] OP_CANCEL = 3'd6;
   localparam logic [MODE_W-1:0] OP_RSVD   = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INSUFF  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd6;

   typedef struct packed {
      logic                model;
      logic [ID_BITS-1:0]  id;
      logic [BYTES_W-1:0]  bytes;
   } resv_entry_type;

   typedef struct packed {
      logic                set;
      logic                clr;
      logic [RIDX_W-1:0]   addr;
      resv_entry_type      data;
   } resv_wr_type;

   typedef struct packed {
      logic                valid;
      resv_entry_type      entry;
   } resv_rd_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [BYTES_W-1:0]  bytes;
      logic [PRIO_W-1:0]   prio;
      logic [TICK_W-1:0]   rem;
      logic                no_limit;
   } waiter_type;

   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      logic                model;
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  granted;
      logic [BYTES_W-1:0]  used;
      logic                last;
   } result_type;

   function automatic logic [CLIENT_W-1:0] to_client(input logic [ID_BITS-1:0] id);
      logic [ID_BITS+CLIENT_W-1:0] t;
      t = {{CLIENT_W{1'b0}}, id};
      return t[CLIENT_W-1:0];
   endfunction

   function automatic logic [ID_BITS-1:0] from_client(input logic [CLIENT_W-1:0] c);
      logic [ID_BITS+CLIENT_W-1:0] t;
      t = {{ID_BITS{1'b0}}, c};
      return t[ID_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/priority_capacity_admission.sv =====
// ---------------------------------------------------------------------------
// priority_capacity_admission
// Byte reservations against a capacity, with a priority wait queue, tick
// timeouts and repeated grants of fitting waiters.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | tuser / tlast
//  req     | in  | client_id, request_bytes, prio, tmo    | mode / -
//  rsp     | out | result_client, granted_bytes, used     | is_model,status / last
//  csr     | in  | capacity (48 bit)                      | -
//
//  Acquires and releases pass a start state, a reservation scan over all
//  RESV_DEPTH entries and a decide state; a grant round scans all waiters
//  and grants the best fitting one, tick visits each waiter and then runs
//  a grant round, cancel emits one result per waiter; each item ends in S_END.
//  The scan is serial, as the reservation memory has one read port.
//  Reset is synchronous; valid flags clear at once, no clearing pass.
//  A stalled result port holds the sequencer at its next result.
// ---------------------------------------------------------------------------
module priority_capacity_admission import pca_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [BYTES_W-1:0]    csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // client_id, request_bytes, priority_req, timeout_ticks
   input  logic [MODE_W-1:0]     req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // result_client, granted_bytes, used_total
   output logic [RSP_USER_W-1:0] rsp_tuser,   // is_model, status
   output logic                  rsp_tlast
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_GINIT  = 4'd4;
   localparam logic [3:0] S_GSCAN  = 4'd5;
   localparam logic [3:0] S_GDO    = 4'd6;
   localparam logic [3:0] S_TICK   = 4'd7;
   localparam logic [3:0] S_CANCEL = 4'd8;
   localparam logic [3:0] S_END    = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [MODE_W-1:0]   op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [TICK_W-1:0]   tmo_ff, tmo_in;
   logic [BYTES_W-1:0]  cap_ff, used_ff, used_in, avail_ff;
   logic [RCNT_W-1:0]   scan_ff, scan_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [RIDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                found_ff, found_in;
   logic [BYTES_W-1:0]  fbytes_ff, fbytes_in;
   logic [RIDX_W-1:0]   fidx_ff, fidx_in;
   logic [WCNT_W-1:0]   idx_ff, idx_in;
   logic [WIDX_W-1:0]   best_ff, best_in;
   logic                best_vld_ff, best_vld_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   waiter_type          wq_ff [WAIT_DEPTH];
   logic [WCNT_W-1:0]   wcnt_ff;
   result_type          pend_ff, pend_in, out_ff, out_in, em;
   logic                pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in;

   logic                em_req, go, out_free, can_emit, flush, is_m, waiting;
   logic                ins, rel, enq, rm, rem_upd, clr_all;
   logic                ins_model;
   logic [ID_BITS-1:0]  ins_id;
   logic [BYTES_W-1:0]  ins_bytes, used_new;
   logic [WIDX_W-1:0]   rsel, rm_idx;
   waiter_type          w, w_new;
   logic [RIDX_W-1:0]   rd_addr;
   resv_wr_type         wr;
   resv_rd_type         rd;
   logic                free_vld;
   logic [RIDX_W-1:0]   free_idx;

   pca_resv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .wr       (wr),
      .rd       (rd),
      .free_vld (free_vld),
      .free_idx (free_idx)
   );

   assign out_free = !out_vld_ff || rsp_tready;
   assign can_emit = !pend_vld_ff || out_free;
   assign is_m     = (op_ff == OP_MACQ) || (op_ff == OP_MREL);
   assign rsel     = (state_ff == S_GDO) ? best_ff : idx_ff[WIDX_W-1:0];
   assign w        = wq_ff[rsel];

   always_comb begin
      waiting = 1'b0;
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         if (WCNT_W'(i) < wcnt_ff && wq_ff[i].id == id_ff) begin
            waiting = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      bytes_in     = bytes_ff;
      prio_in      = prio_ff;
      tmo_in       = tmo_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      fbytes_in    = fbytes_ff;
      fidx_in      = fidx_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_vld_in  = best_vld_ff;
      best_prio_in = best_prio_ff;
      rd_addr      = scan_ff[RIDX_W-1:0];
      em_req       = 1'b0;
      flush        = 1'b0;
      ins          = 1'b0;
      rel          = 1'b0;
      enq          = 1'b0;
      rm           = 1'b0;
      rem_upd      = 1'b0;
      clr_all      = 1'b0;
      rm_idx       = rsel;
      ins_model    = is_m;
      ins_id       = id_ff;
      ins_bytes    = bytes_ff;
      em.client    = to_client(id_ff);
      em.model     = is_m;
      em.status    = ST_OK;
      em.granted   = '0;
      em.last      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               id_in    = from_client(req_tdata[CLIENT_W-1:0]);
               bytes_in = req_tdata[CLIENT_W +: BYTES_W];
               prio_in  = req_tdata[CLIENT_W+BYTES_W +: PRIO_W];
               tmo_in   = req_tdata[CLIENT_W+BYTES_W+PRIO_W +: TICK_W];
               state_in = S_START;
            end
         end
         S_START: begin
            scan_in  = '0;
            found_in = 1'b0;
            idx_in   = '0;
            unique case (op_ff)
               OP_TRY, OP_MACQ: begin
                  if (bytes_ff == '0) begin
                     em_req    = 1'b1;
                     em.status = ST_INVALID;
                     state_in  = S_END;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               OP_WAIT: begin
                  if (bytes_ff == '0) begin
                     em_req    = 1'b1;
                     em.status = ST_INVALID;
                     state_in  = S_END;
                  end else if (bytes_ff > cap_ff) begin
                     em_req    = 1'b1;
                     em.status = ST_INSUFF;
                     state_in  = S_END;
                  end else begin
                     if (tmo_ff == '0) begin
                        op_in = OP_TRY;
                     end
                     state_in = S_FIND;
                  end
               end
               OP_REL, OP_MREL: state_in = S_FIND;
               OP_TICK:         state_in = S_TICK;
               OP_CANCEL:       state_in = S_CANCEL;
               default:         state_in = S_END;
            endcase
         end
         S_FIND: begin
            if (scan_ff != RCNT_W'(RESV_DEPTH)) begin
               scan_in    = scan_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[RIDX_W-1:0];
            end
            if (chk_vld_ff && rd.valid && rd.entry.model == is_m && rd.entry.id == id_ff) begin
               found_in  = 1'b1;
               fbytes_in = rd.entry.bytes;
               fidx_in   = chk_idx_ff;
            end
            if (scan_ff == RCNT_W'(RESV_DEPTH) && !chk_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            em_req   = 1'b1;
            state_in = S_END;
            unique case (op_ff)
               OP_TRY, OP_MACQ: begin
                  if (found_ff || (!is_m && waiting)) begin
                     em.status = ST_DUP;
                  end else if (bytes_ff > avail_ff) begin
                     em.status = ST_INSUFF;
                  end else if (!free_vld) begin
                     em.status = ST_FULL;
                  end else begin
                     ins        = 1'b1;
                     em.granted = bytes_ff;
                     if (op_ff == OP_TRY) begin
                        state_in = S_GINIT;
                     end
                  end
               end
               OP_WAIT: begin
                  if (found_ff || waiting) begin
                     em.status = ST_DUP;
                  end else if (wcnt_ff == '0 && bytes_ff <= avail_ff) begin
                     if (!free_vld) begin
                        em.status = ST_FULL;
                     end else begin
                        ins        = 1'b1;
                        em.granted = bytes_ff;
                     end
                  end else if (wcnt_ff == WCNT_W'(WAIT_DEPTH)) begin
                     em.status = ST_FULL;
                  end else begin
                     em_req   = 1'b0;
                     enq      = 1'b1;
                     state_in = S_GINIT;
                  end
               end
               OP_REL, OP_MREL: begin
                  if (!found_ff) begin
                     em.status = ST_UNKNOWN;
                  end else begin
                     rel        = 1'b1;
                     em.granted = fbytes_ff;
                     state_in   = S_GINIT;
                  end
               end
               default: em_req = 1'b0;
            endcase
         end
         S_GINIT: begin
            idx_in      = '0;
            best_vld_in = 1'b0;
            state_in    = S_GSCAN;
         end
         S_GSCAN: begin
            if (idx_ff < wcnt_ff) begin
               if (w.bytes <= avail_ff && (!best_vld_ff || w.prio > best_prio_ff)) begin
                  best_in      = idx_ff[WIDX_W-1:0];
                  best_prio_in = w.prio;
                  best_vld_in  = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else if (free_vld && best_vld_ff) begin
               state_in = S_GDO;
            end else begin
               state_in = S_END;
            end
         end
         S_GDO: begin
            em_req     = 1'b1;
            ins        = 1'b1;
            ins_model  = 1'b0;
            ins_id     = w.id;
            ins_bytes  = w.bytes;
            rm         = 1'b1;
            em.client  = to_client(w.id);
            em.model   = 1'b0;
            em.granted = w.bytes;
            state_in   = S_GINIT;
         end
         S_TICK: begin
            if (idx_ff < wcnt_ff) begin
               if (w.no_limit) begin
                  idx_in = idx_ff + 1'b1;
               end else if (w.rem <= TICK_W'(1)) begin
                  em_req    = 1'b1;
                  em.client = to_client(w.id);
                  em.model  = 1'b0;
                  em.status = ST_TIMEOUT;
                  rm        = 1'b1;
               end else begin
                  rem_upd = 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
            end else begin
               state_in = S_GINIT;
            end
         end
         S_CANCEL: begin
            if (idx_ff < wcnt_ff) begin
               em_req    = 1'b1;
               em.client = to_client(w.id);
               em.model  = 1'b0;
               em.status = ST_TIMEOUT;
               idx_in    = idx_ff + 1'b1;
            end else begin
               clr_all  = 1'b1;
               state_in = S_END;
            end
         end
         S_END: begin
            if (pend_vld_ff) begin
               if (out_free) begin
                  flush    = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ins) begin
         used_new = used_ff + ins_bytes;
      end else if (rel) begin
         used_new = (used_ff >= fbytes_ff) ? used_ff - fbytes_ff : '0;
      end else begin
         used_new = used_ff;
      end
      em.used = used_new;

      go = !em_req || can_emit;
      if (!go) begin
         state_in = state_ff;
         idx_in   = idx_ff;
         ins      = 1'b0;
         rel      = 1'b0;
         rm       = 1'b0;
      end
      used_in = go ? used_new : used_ff;

      wr.set        = ins;
      wr.clr        = rel;
      wr.addr       = rel ? fidx_ff : free_idx;
      wr.data.model = ins_model;
      wr.data.id    = ins_id;
      wr.data.bytes = ins_bytes;

      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      if (em_req && can_emit) begin
         if (pend_vld_ff) begin
            out_in     = pend_ff;
            out_vld_in = 1'b1;
         end
         pend_in     = em;
         pend_vld_in = 1'b1;
      end else if (flush) begin
         out_in      = pend_ff;
         out_in.last = 1'b1;
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   assign w_new.id       = id_ff;
   assign w_new.bytes    = bytes_ff;
   assign w_new.prio     = prio_ff;
   assign w_new.rem      = tmo_ff;
   assign w_new.no_limit = (tmo_ff == TMO_FOREVER);

   always_ff @(posedge clock) begin
      if (enq) begin
         wq_ff[wcnt_ff[WIDX_W-1:0]] <= w_new;
      end
      if (rem_upd) begin
         wq_ff[rsel].rem <= w.rem - TICK_W'(1);
      end
      if (rm) begin
         for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
            if (i >= int'(rm_idx)) begin
               wq_ff[i] <= wq_ff[i+1];
            end
         end
      end
      op_ff        <= op_in;
      id_ff        <= id_in;
      bytes_ff     <= bytes_in;
      prio_ff      <= prio_in;
      tmo_ff       <= tmo_in;
      avail_ff     <= (cap_ff > used_ff) ? cap_ff - used_ff : '0;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      fbytes_ff    <= fbytes_in;
      fidx_ff      <= fidx_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cap_ff      <= CAP_RESET;
         used_ff     <= '0;
         wcnt_ff     <= '0;
         chk_vld_ff  <= 1'b0;
         best_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         chk_vld_ff  <= chk_vld_in;
         best_vld_ff <= best_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (clr_all) begin
            wcnt_ff <= '0;
         end else if (enq) begin
            wcnt_ff <= wcnt_ff + 1'b1;
         end else if (rm) begin
            wcnt_ff <= wcnt_ff - 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.used, out_ff.granted, out_ff.client};
   assign rsp_tuser  = {out_ff.status, out_ff.model};
   assign rsp_tlast  = out_ff.last;

`ifndef SYNTH
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= WCNT_W'(WAIT_DEPTH))
      else $error("waiter count beyond queue depth");
   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_vld_ff)
      else $error("idle with a result still staged");
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END && !pend_vld_ff) |=> state_ff == S_IDLE)
      else $error("end of item did not return to idle");
`endif

endmodule

// ===== hw/rtl/pca_resv_store.sv =====
// ---------------------------------------------------------------------------
// pca_resv_store
// Reservation memory with registered read, per-entry valid flags and a
// registered first-free-entry finder.
// ---------------------------------------------------------------------------
module pca_resv_store import pca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [RIDX_W-1:0] rd_addr,
   input  resv_wr_type       wr,
   output resv_rd_type       rd,
   output logic              free_vld,
   output logic [RIDX_W-1:0] free_idx
);

   resv_entry_type           mem_ff [RESV_DEPTH];
   logic [RESV_DEPTH-1:0]    valid_ff;
   resv_rd_type              rd_ff;
   logic                     free_vld_ff, free_vld_in;
   logic [RIDX_W-1:0]        free_idx_ff, free_idx_in;

   always_ff @(posedge clock) begin
      if (wr.set) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_ff.entry <= mem_ff[rd_addr];
      rd_ff.valid <= valid_ff[rd_addr];
      free_idx_ff <= free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         free_vld_ff <= 1'b0;
      end else begin
         free_vld_ff <= free_vld_in;
         if (wr.set) begin
            valid_ff[wr.addr] <= 1'b1;
         end else if (wr.clr) begin
            valid_ff[wr.addr] <= 1'b0;
         end
      end
   end

   always_comb begin
      free_vld_in = 1'b0;
      free_idx_in = '0;
      for (int i = RESV_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_vld_in = 1'b1;
            free_idx_in = RIDX_W'(i);
         end
      end
   end

   assign rd       = rd_ff;
   assign free_vld = free_vld_ff;
   assign free_idx = free_idx_ff;

`ifndef SYNTH
   a_set_free: assert property (@(posedge clock) disable iff (reset)
      wr.set |-> !valid_ff[wr.addr])
      else $error("insert into an occupied reservation entry");
   a_clr_held: assert property (@(posedge clock) disable iff (reset)
      wr.clr |-> valid_ff[wr.addr])
      else $error("release of an empty reservation entry");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Priority capacity admission testbench
// Drives acquire, wait, release, model, tick and cancel requests through the
// request stream, predicts every response beat with a behavioral model of
// reservations and the priority wait queue, and compares field by field.
// ---------------------------------------------------------------------------
module testbench;
   import pca_pkg::*;

   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [CLIENT_W-1:0] id;
      logic [BYTES_W-1:0]  bytes;
      logic [PRIO_W-1:0]   prio;
      logic [TICK_W-1:0]   tmo;
      bit                  has_exp;
      logic [STATUS_W-1:0] exp_status;
   } stim_type;

   typedef struct {
      bit                 valid;
      bit                 model;
      logic [ID_BITS-1:0] id;
      logic [BYTES_W-1:0] bytes;
   } grant_type;

   typedef struct {
      logic [ID_BITS-1:0] id;
      logic [BYTES_W-1:0] bytes;
      logic [PRIO_W-1:0]  prio;
      logic [TICK_W-1:0]  rem;
      bit                 no_limit;
   } queued_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [BYTES_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;

   priority_capacity_admission dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   logic [BYTES_W-1:0] cap_reg;
   logic [BYTES_W-1:0] used_reg;
   grant_type          grants[RESV_DEPTH];
   queued_type         queue[$];
   result_type         pending[$];
   int errors = 0, beats = 0, items = 0, cycles = 0;
   bit no_idle = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [BYTES_W-1:0] avail();
      return (cap_reg > used_reg) ? cap_reg - used_reg : '0;
   endfunction

   function automatic int find_grant(logic [ID_BITS-1:0] id, bit model);
      for (int i = 0; i < RESV_DEPTH; i++)
         if (grants[i].valid && grants[i].model == model && grants[i].id == id) return i;
      return -1;
   endfunction

   function automatic int open_slot();
      for (int i = 0; i < RESV_DEPTH; i++)
         if (!grants[i].valid) return i;
      return -1;
   endfunction

   function automatic bit queued(logic [ID_BITS-1:0] id);
      foreach (queue[i]) if (queue[i].id == id) return 1;
      return 0;
   endfunction

   function automatic void push(logic [ID_BITS-1:0] id, bit model, logic [STATUS_W-1:0] st,
                                logic [BYTES_W-1:0] b);
      result_type r;
      r.client = id;
      r.model = model;
      r.status = st;
      r.granted = b;
      r.used = used_reg;
      r.last = 0;
      pending.insert(pending.size(), r);
   endfunction

   function automatic void take(int slot, logic [ID_BITS-1:0] id, bit model,
                                logic [BYTES_W-1:0] b);
      grants[slot] = '{1, model, id, b};
      used_reg = used_reg + b;
   endfunction

   function automatic void serve_waiters();
      int slot, best;
      forever begin
         slot = open_slot();
         best = -1;
         if (slot < 0) break;
         foreach (queue[i])
            if (queue[i].bytes <= avail() && (best < 0 || queue[i].prio > queue[best].prio))
               best = i;
         if (best < 0) break;
         take(slot, queue[best].id, 0, queue[best].bytes);
         push(queue[best].id, 0, ST_OK, queue[best].bytes);
         queue.delete(best);
      end
   endfunction

   function automatic void try_take(logic [ID_BITS-1:0] id, logic [BYTES_W-1:0] b);
      int slot;
      if (b == 0) begin push(id, 0, ST_INVALID, 0); return; end
      if (find_grant(id, 0) >= 0 || queued(id)) begin push(id, 0, ST_DUP, 0); return; end
      if (b > avail()) begin push(id, 0, ST_INSUFF, 0); return; end
      slot = open_slot();
      if (slot < 0) begin push(id, 0, ST_FULL, 0); return; end
      take(slot, id, 0, b);
      push(id, 0, ST_OK, b);
      serve_waiters();
   endfunction

   function automatic void predict(stim_type s);
      int n0, slot, i;
      queued_type q;
      n0 = pending.size();
      case (s.mode)
         OP_TRY: try_take(s.id, s.bytes);
         OP_WAIT: begin
            if (s.bytes == 0) push(s.id, 0, ST_INVALID, 0);
            else if (s.bytes > cap_reg) push(s.id, 0, ST_INSUFF, 0);
            else if (s.tmo == 0) try_take(s.id, s.bytes);
            else if (find_grant(s.id, 0) >= 0 || queued(s.id)) push(s.id, 0, ST_DUP, 0);
            else if (queue.size() == 0 && s.bytes <= avail()) begin
               slot = open_slot();
               if (slot < 0) push(s.id, 0, ST_FULL, 0);
               else begin
                  take(slot, s.id, 0, s.bytes);
                  push(s.id, 0, ST_OK, s.bytes);
               end
            end else if (queue.size() >= WAIT_DEPTH) push(s.id, 0, ST_FULL, 0);
            else begin
               q = '{s.id, s.bytes, s.prio, s.tmo, s.tmo == TMO_FOREVER};
               queue.insert(queue.size(), q);
               serve_waiters();
            end
         end
         OP_REL, OP_MREL: begin
            slot = find_grant(s.id, s.mode == OP_MREL);
            if (slot < 0) push(s.id, s.mode == OP_MREL, ST_UNKNOWN, 0);
            else begin
               grants[slot].valid = 0;
               used_reg = (used_reg >= grants[slot].bytes) ? used_reg - grants[slot].bytes : '0;
               push(s.id, s.mode == OP_MREL, ST_OK, grants[slot].bytes);
               serve_waiters();
            end
         end
         OP_MACQ: begin
            if (s.bytes == 0) push(s.id, 1, ST_INVALID, 0);
            else if (find_grant(s.id, 1) >= 0) push(s.id, 1, ST_DUP, 0);
            else if (s.bytes > avail()) push(s.id, 1, ST_INSUFF, 0);
            else begin
               slot = open_slot();
               if (slot < 0) push(s.id, 1, ST_FULL, 0);
               else begin
                  take(slot, s.id, 1, s.bytes);
                  push(s.id, 1, ST_OK, s.bytes);
               end
            end
         end
         OP_TICK: begin
            i = 0;
            while (i < queue.size()) begin
               if (!queue[i].no_limit) begin
                  if (queue[i].rem > 0) queue[i].rem--;
                  if (queue[i].rem == 0) begin
                     push(queue[i].id, 0, ST_TIMEOUT, 0);
                     queue.delete(i);
                     continue;
                  end
               end
               i++;
            end
            serve_waiters();
         end
         OP_CANCEL: begin
            foreach (queue[k]) push(queue[k].id, 0, ST_TIMEOUT, 0);
            queue.delete();
         end
         default: ;
      endcase
      if (pending.size() > n0) pending[pending.size()-1].last = 1;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.client = rsp_tdata[CLIENT_W-1:0];
         got.granted = rsp_tdata[CLIENT_W +: BYTES_W];
         got.used = rsp_tdata[CLIENT_W+BYTES_W +: BYTES_W];
         got.model = rsp_tuser[0];
         got.status = rsp_tuser[1 +: STATUS_W];
         got.last = rsp_tlast;
         beats++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected beat %p", got);
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("Mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 34);

   task automatic write_capacity(logic [BYTES_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      cap_reg = v;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send(stim_type s);
      int first;
      while (!no_idle && $urandom_range(99) < 34) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= s.mode;
      req_tdata <= {s.tmo, s.prio, s.bytes, s.id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      first = pending.size();
      predict(s);
      if (s.has_exp && (pending.size() <= first || pending[first].status != s.exp_status)) begin
         errors++;
         if (errors <= 10) $display("Directed row %0d: status not %0d", items, s.exp_status);
      end
      items++;
   endtask

   function automatic stim_type row(logic [MODE_W-1:0] m, int id, logic [BYTES_W-1:0] b,
                                    int p, int t, bit he = 0,
                                    logic [STATUS_W-1:0] st = ST_OK);
      return '{m, id[7:0], b, p[7:0], t[15:0], he, st};
   endfunction

   function automatic stim_type rand_item();
      stim_type s;
      int r;
      logic [BYTES_W-1:0] b;
      r = $urandom_range(99);
      s.mode = (r < 30) ? OP_WAIT : (r < 50) ? OP_TRY : (r < 68) ? OP_REL :
               (r < 76) ? OP_MACQ : (r < 82) ? OP_MREL : (r < 95) ? OP_TICK :
               (r < 98) ? OP_CANCEL : OP_RSVD;
      s.id = (r % 9 == 0) ? CLIENT_W'($urandom_range(255)) : CLIENT_W'($urandom_range(15));
      b = $urandom_range(cap_reg > 5 ? 5 : 1, 1) * (cap_reg / 6 + 1);
      if ($urandom_range(19) == 0) b = BYTES_W'({$urandom, $urandom});
      if ($urandom_range(29) == 0) b = 0;
      s.bytes = b;
      s.prio = PRIO_W'($urandom_range(255));
      r = $urandom_range(9);
      s.tmo = (r == 0) ? '0 : (r == 1) ? TMO_FOREVER :
              (r == 2) ? TICK_W'($urandom_range(65535)) : TICK_W'($urandom_range(6, 1));
      s.has_exp = 0;
      s.exp_status = ST_OK;
      return s;
   endfunction

   stim_type table_rows[$];

   initial begin
      logic [BYTES_W-1:0] caps[4];
      for (int i = 0; i < RESV_DEPTH; i++) grants[i].valid = 0;
      cap_reg = CAP_RESET;
      used_reg = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      table_rows = '{
         row(OP_REL, 3, 0, 0, 0, 1, ST_UNKNOWN),
         row(OP_MREL, 255, 0, 0, 0, 1, ST_UNKNOWN),
         row(OP_TRY, 0, 0, 0, 0, 1, ST_INVALID),
         row(OP_WAIT, 1, 0, 0, 5, 1, ST_INVALID),
         row(OP_MACQ, 2, 0, 0, 0, 1, ST_INVALID),
         row(OP_WAIT, 1, 48'hFFFF_FFFF_FFFF, 255, 5, 1, ST_INSUFF),
         row(OP_TRY, 255, 48'h3_0000_0000, 0, 0, 1, ST_OK),
         row(OP_TRY, 255, 1, 0, 0, 1, ST_DUP),
         row(OP_TRY, 4, 48'h2_0000_0000, 0, 0, 1, ST_INSUFF),
         row(OP_WAIT, 5, 48'h2_0000_0000, 10, 2, 0),
         row(OP_WAIT, 6, 48'h2_0000_0000, 200, TMO_FOREVER, 0),
         row(OP_WAIT, 7, 48'h2_0000_0000, 200, 3, 0),
         row(OP_WAIT, 6, 5, 0, 3, 1, ST_DUP),
         row(OP_WAIT, 8, 5, 0, 0, 0),
         row(OP_MACQ, 255, 48'h1000, 0, 0, 1, ST_OK),
         row(OP_MACQ, 255, 48'h1000, 0, 0, 1, ST_DUP),
         row(OP_TICK, 0, 0, 0, 0, 0),
         row(OP_TICK, 0, 0, 0, 0, 0),
         row(OP_REL, 255, 0, 0, 0, 1, ST_OK),
         row(OP_MREL, 255, 0, 0, 0, 1, ST_OK),
         row(OP_CANCEL, 0, 0, 0, 0, 0),
         row(OP_RSVD, 9, 1, 1, 1, 0),
         row(OP_TICK, 0, 0, 0, 0, 0)
      };
      foreach (table_rows[i]) send(table_rows[i]);
      drain();

      caps = '{48'd1, 48'hFFFF_FFFF_FFFF, 48'd1000, 48'h4_0000_0000};
      for (int ph = 0; ph < 4; ph++) begin
         write_capacity(caps[ph]);
         no_idle = (ph == 2);
         for (int n = 0; n < 50; n++) send(rand_item());
         if (ph == 1) for (int k = 0; k < 40; k++) send(row(OP_TRY, 100 + k, 1, 0, 0));
         drain();
      end
      no_idle = 0;

      $display("Ran %0d request beats over all modes and four capacities", items);
      $display("Checked %0d response beats against the predictor", beats);
      if (errors == 0 && pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
